>>> hdl/phs_pkg.sv
// ---------------------------------------------------------------------------
// phs_pkg
// shared constants and types of the point hash set
// ---------------------------------------------------------------------------
package phs_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int WAYS_DEF        = 4;
    localparam int HASH_SHIFT      = 10;
    localparam int CFG_W           = 11;
    localparam int COORD_W         = 32;
    localparam int KEY_W           = 2 * COORD_W;
    localparam int IDX_OUT_W       = 10;
    localparam int TOTAL_W         = 13;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 11'd701;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // request into the remainder unit
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [CFG_W-1:0]   divisor;
    } t_div_req;

    // answer from the remainder unit
    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> hdl/point_hash_set_unit.sv
// ---------------------------------------------------------------------------
// point_hash_set_unit
// set of 2-d points in hashed buckets with a bounded number of ways
// ---------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tuser req_type, tdata point_x, point_y
//  m_axis    out        tuser flags, tdata bucket_index, element_total
//  cfg       in         bucket_count, always ready
//
//  on a miss the result waits on the 32 step remainder unit and on the way scan
//  through the registered key ram, which reads and compares each filled way in
//  turn; the next beat is taken once the result is in the output register
//  after reset the fill ram is cleared, all MAX_BUCKETS entries, s_axis not ready
//  one item at a time; a finished result waits in the output register when
//  m_axis stalls, the next item may run meanwhile but holds in its last step
// ---------------------------------------------------------------------------
module point_hash_set_unit #(
    parameter int MAX_BUCKETS = phs_pkg::MAX_BUCKETS_DEF,
    parameter int WAYS        = phs_pkg::WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_x, point_y
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // bucket_index, element_total, zero pad
    output logic [2:0]  m_axis_tuser,   // was_present, inserted, bucket_full
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data      // bucket_count
);

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_FRD  = 4'd3;
    localparam logic [3:0] ST_FLAT = 4'd4;
    localparam logic [3:0] ST_SCAN = 4'd5;
    localparam logic [3:0] ST_CMP  = 4'd6;
    localparam logic [3:0] ST_DEC  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]                      r_state, n_state;
    logic [BW-1:0]                   r_clr, n_clr;
    logic [phs_pkg::CFG_W-1:0]       r_cfg;
    logic                            r_type;
    logic [phs_pkg::KEY_W-1:0]       r_key;
    logic [BW-1:0]                   r_bucket, n_bucket;
    logic [FW-1:0]                   r_fill, n_fill;
    logic [FW-1:0]                   r_way, n_way;
    logic                            r_present, n_present;
    logic                            r_added, n_added;
    logic                            r_full, n_full;
    logic [phs_pkg::TOTAL_W-1:0]     r_count, n_count;
    logic                            r_oval, n_oval;
    logic [2:0]                      r_ouser;
    logic [phs_pkg::IDX_OUT_W-1:0]   r_oidx;
    logic [phs_pkg::TOTAL_W-1:0]     r_otot;

    logic [phs_pkg::CFG_W-1:0]       eff_buckets;
    phs_pkg::t_div_req               div_req;
    phs_pkg::t_div_rsp               div_rsp;
    logic                            fill_we;
    logic [BW-1:0]                   fill_waddr;
    logic [FW-1:0]                   fill_wdata;
    logic [FW-1:0]                   fill_rdata;
    logic                            key_we;
    logic [phs_pkg::KEY_W-1:0]       key_rdata;
    logic                            in_beat;
    logic                            load_out;

    // zero reads as one bucket, too many clamp to the ram size
    always_comb begin
        if (r_cfg == '0) begin
            eff_buckets = phs_pkg::CFG_W'(1);
        end else if (32'(r_cfg) > 32'(MAX_BUCKETS)) begin
            eff_buckets = phs_pkg::CFG_W'(MAX_BUCKETS);
        end else begin
            eff_buckets = r_cfg;
        end
    end

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign load_out = (r_state == ST_DONE) && (!r_oval || m_axis_tready);

    assign div_req.start    = in_beat;
    assign div_req.dividend = s_axis_tdata[phs_pkg::COORD_W-1:0] << phs_pkg::HASH_SHIFT;
    assign div_req.divisor  = eff_buckets;

    phs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign fill_we    = (r_state == ST_CLR) || (r_state == ST_DEC && n_added);
    assign fill_waddr = (r_state == ST_CLR) ? r_clr : r_bucket;
    assign fill_wdata = (r_state == ST_CLR) ? '0 : r_fill + 1'b1;

    phs_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_BUCKETS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (r_bucket),
        .o_rdata (fill_rdata)
    );

    assign key_we = (r_state == ST_DEC) && n_added;

    phs_ram #(
        .WIDTH (phs_pkg::KEY_W),
        .DEPTH (MAX_BUCKETS << WW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr ({r_bucket, r_fill[WW-1:0]}),
        .i_wdata (r_key),
        .i_raddr ({r_bucket, r_way[WW-1:0]}),
        .o_rdata (key_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_bucket  = r_bucket;
        n_fill    = r_fill;
        n_way     = r_way;
        n_present = r_present;
        n_added   = r_added;
        n_full    = r_full;
        n_count   = r_count;
        n_oval    = r_oval;
        if (m_axis_tready) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            ST_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == BW'(MAX_BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_bucket = BW'(div_rsp.rem);
                    n_state  = ST_FRD;
                end
            end
            ST_FRD: begin
                n_state = ST_FLAT;
            end
            ST_FLAT: begin
                n_fill    = (fill_rdata > FW'(WAYS)) ? FW'(WAYS) : fill_rdata;
                n_way     = '0;
                n_present = 1'b0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                n_state = (r_way == r_fill) ? ST_DEC : ST_CMP;
            end
            ST_CMP: begin
                if (key_rdata == r_key) begin
                    n_present = 1'b1;
                    n_state   = ST_DEC;
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_DEC: begin
                n_added = 1'b0;
                n_full  = 1'b0;
                if (r_type == phs_pkg::REQ_INSERT && !r_present) begin
                    if (r_fill >= FW'(WAYS)) begin
                        n_full = 1'b1;
                    end else begin
                        n_added = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_oval  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_oval  <= 1'b0;
            r_cfg   <= phs_pkg::BUCKET_COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_oval  <= n_oval;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
        if (in_beat) begin
            r_type <= s_axis_tuser;
            r_key  <= s_axis_tdata;
        end
        r_bucket  <= n_bucket;
        r_fill    <= n_fill;
        r_way     <= n_way;
        r_present <= n_present;
        r_added   <= n_added;
        r_full    <= n_full;
        if (load_out) begin
            r_ouser <= {r_full, r_added, r_present};
            r_oidx  <= phs_pkg::IDX_OUT_W'(r_bucket);
            r_otot  <= r_count;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tdata  = {1'b0, r_otot, r_oidx};

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2])
            && !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("conflicting result flags");

    a_count_only_on_insert : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DEC && r_state != ST_CLR) |=> $stable(r_count))
        else $error("element count moved outside the decide step");

    a_scan_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CMP |-> r_way < r_fill)
        else $error("way scan ran past the bucket fill");

    a_fill_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_fill <= FW'(WAYS))
        else $error("bucket fill above way count");

endmodule

>>> hdl/phs_ram.sv
// ---------------------------------------------------------------------------
// phs_ram
// generic simple dual port ram, one write and one registered read
// ---------------------------------------------------------------------------
module phs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/phs_div.sv
// ---------------------------------------------------------------------------
// phs_div
// restoring remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
module phs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phs_pkg::t_div_req i_req,
    output phs_pkg::t_div_rsp o_rsp
);

    localparam int CW = $clog2(phs_pkg::COORD_W);

    logic                        r_busy, n_busy;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [phs_pkg::COORD_W-1:0] r_num, n_num;
    logic [phs_pkg::CFG_W-1:0]   r_den, n_den;
    logic [phs_pkg::CFG_W-1:0]   r_rem, n_rem;
    logic                        r_done, n_done;
    logic [phs_pkg::CFG_W:0]     trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_done = 1'b0;
        trial  = {r_rem, r_num[phs_pkg::COORD_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_req.dividend;
            n_den  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in CFG_W bits
            if (trial >= {1'b0, r_den}) begin
                trial = trial - {1'b0, r_den};
            end
            n_rem = trial[phs_pkg::CFG_W-1:0];
            n_num = {r_num[phs_pkg::COORD_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(phs_pkg::COORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

>>> verif/point_hash_set_unit_test.sv
// ---------------------------------------------------------------------------
// point_hash_set_unit_test
// drives insert and lookup beats into the point hash set, predicts each
// result from a local copy of the buckets and checks every output beat
// ---------------------------------------------------------------------------
module point_hash_set_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = phs_pkg::MAX_BUCKETS_DEF;
    localparam int NW = phs_pkg::WAYS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                        kind;
        logic [phs_pkg::COORD_W-1:0] px;
        logic [phs_pkg::COORD_W-1:0] py;
    } t_point_req;

    typedef struct packed {
        logic                          was_present;
        logic                          inserted;
        logic                          bucket_full;
        logic [phs_pkg::IDX_OUT_W-1:0] bucket_index;
        logic [phs_pkg::TOTAL_W-1:0]   element_total;
    } t_set_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    point_hash_set_unit u_top (.*);

    // predictor state
    logic [phs_pkg::KEY_W-1:0]   point_store [NB*NW];
    int unsigned                 fill_level [NB];
    logic [phs_pkg::TOTAL_W-1:0] point_total;
    logic [phs_pkg::CFG_W-1:0]   bucket_div;

    t_point_req  pending_points [$];
    t_set_answer expected_answers [$];
    int  failures = 0;
    int  quiet_cycles = 0;
    bit  idle_ok = 1'b1;
    bit  hold_send = 1'b0;
    bit  in_accepted = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic t_set_answer predict_answer(t_point_req r);
        t_set_answer a;
        logic [phs_pkg::KEY_W-1:0] key;
        int unsigned nb;
        int unsigned bk;
        int unsigned fl;
        key = {r.py, r.px};
        nb = (bucket_div == '0) ? 1 : ((32'(bucket_div) > NB) ? NB : 32'(bucket_div));
        bk = (r.px << phs_pkg::HASH_SHIFT) % nb;
        fl = fill_level[bk];
        a = '0;
        for (int w = 0; w < fl; w++)
            if (point_store[bk*NW+w] == key) a.was_present = 1'b1;
        if (r.kind == phs_pkg::REQ_INSERT && !a.was_present) begin
            if (fl >= NW) begin
                a.bucket_full = 1'b1;
            end else begin
                point_store[bk*NW+fl] = key;
                fill_level[bk] = fl + 1;
                point_total = point_total + 1'b1;
                a.inserted = 1'b1;
            end
        end
        a.bucket_index = bk[phs_pkg::IDX_OUT_W-1:0];
        a.element_total = point_total;
        return a;
    endfunction

    initial forever #5 i_clk = ~i_clk;

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_accepted) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (hold_send) begin
                s_axis_tvalid <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 13);
                s_axis_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                t_point_req r;
                r = pending_points.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= r.kind;
                s_axis_tdata <= {r.py, r.px};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_accepted <= s_axis_tvalid && s_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                t_set_answer got, want;
                got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
                       m_axis_tdata[9:0], m_axis_tdata[22:10]};
                if (expected_answers.size() == 0) begin
                    $display("%0t unexpected beat, actual %h", $time, got);
                    failures++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.was_present !== want.was_present ||
                        got.inserted !== want.inserted ||
                        got.bucket_full !== want.bucket_full ||
                        got.bucket_index !== want.bucket_index ||
                        got.element_total !== want.element_total ||
                        m_axis_tdata[23] !== 1'b0) begin
                        $display("%0t mismatch: expected %h actual %h", $time, want, got);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(
                    predict_answer({s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]}));
            end
        end else begin
            in_accepted <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [phs_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bucket_div = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_x(int unsigned mode);
        case (mode)
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 7) << 22;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [31:0] xs [8];
        logic [31:0] ys [8];
        for (int k = 0; k < 8; k++) begin
            xs[k] = rand_x(k % 3);
            ys[k] = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            t_point_req r;
            int k;
            k = $urandom_range(0, 7);
            r.kind = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
                r.px = rand_x($urandom_range(0, 2));
                r.py = $urandom;
            end else begin
                r.px = xs[k];
                r.py = ($urandom_range(0, 1)) ? ys[k] : ys[k] ^ $urandom_range(0, 3);
            end
            pending_points.push_back(r);
        end
    endtask

    initial begin
        logic [phs_pkg::CFG_W-1:0] cfgs [6];
        cfgs = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd37, 11'd3};
        for (int i = 0; i < NB*NW; i++) point_store[i] = '0;
        for (int i = 0; i < NB; i++) fill_level[i] = 0;
        point_total = '0;
        bucket_div = phs_pkg::BUCKET_COUNT_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, present insert, full bucket, lookups
        pending_points.push_back('{phs_pkg::REQ_LOOKUP, 32'h0, 32'h0});
        pending_points.push_back('{phs_pkg::REQ_INSERT, 32'h0, 32'h0});
        pending_points.push_back('{phs_pkg::REQ_INSERT, 32'h0, 32'h0});
        pending_points.push_back('{phs_pkg::REQ_LOOKUP, 32'h0, 32'h0});
        pending_points.push_back('{phs_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_points.push_back('{phs_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        for (int i = 1; i <= 5; i++)
            pending_points.push_back('{phs_pkg::REQ_INSERT, 32'h0, i});
        pending_points.push_back('{phs_pkg::REQ_LOOKUP, 32'h0, 32'd4});
        pending_points.push_back('{phs_pkg::REQ_LOOKUP, 32'hAAAA_5555, 32'h5555_AAAA});
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_buckets(cfgs[p]);
            random_phase(p == 5 ? 150 : 330);
            if (p == 2) begin
                // sender holds off until every answer is back
                while (pending_points.size() >= 160) @(posedge i_clk);
                hold_send = 1'b1;
                while (s_axis_tvalid || expected_answers.size() > 0) @(posedge i_clk);
                hold_send = 1'b0;
            end
            if (p == 5) begin
                wait_drained();
                idle_ok = 1'b0;
                random_phase(100);
            end
            wait_drained();
        end

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> sim.f
hdl/phs_pkg.sv
hdl/phs_ram.sv
hdl/phs_div.sv
hdl/point_hash_set_unit.sv
verif/point_hash_set_unit_test.sv
